### src/rcd_pkg.sv
// Shared constants, codes and types for the restricted circular deque.
package rcd_pkg;

    // Store geometry.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Operation codes carried by a request.
    typedef enum logic [2:0] {
        OP_INS_RIGHT = 3'd0,
        OP_INS_LEFT  = 3'd1,
        OP_DEL_LEFT  = 3'd2,
        OP_DEL_RIGHT = 3'd3,
        OP_LIST      = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_UNDERFLOW = 3'd2,
        STS_REFUSED   = 3'd3,
        STS_EMPTY     = 3'd4
    } status_t;

    // Restriction mode values.
    localparam logic MODE_INPUT_RESTR  = 1'b0;
    localparam logic MODE_OUTPUT_RESTR = 1'b1;

    // What one cell does with its entry in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD
    } cell_cmd_t;

    // Control bundle handed to each cell.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [DATA_W-1:0]  load_data;
    } cell_ctrl_t;

endpackage

### src/rcd_cell.sv
// One entry of the deque chain: holds a value and takes it from a neighbour or a load.
module rcd_cell
    import rcd_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Select the new entry from the command.
    always_comb begin
        case (ctrl.cmd)
            CELL_FROM_LEFT:  data_next = left_data;
            CELL_FROM_RIGHT: data_next = right_data;
            CELL_LOAD:       data_next = ctrl.load_data;
            default:         data_next = data_reg;
        endcase
    end

    // Entry storage needs no reset; the fill count says which entries are live.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### src/restricted_circular_deque.sv
// Top level of the restricted deque: request control, output stage and the chain of cells.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------------
//  request  | in        | s_valid / s_ready    | s_operation[2:0], s_value[31:0]
//  result   | out       | m_valid / m_ready    | m_status[2:0], m_data[31:0], m_last
//  config   | in        | cfg_valid / cfg_ready| cfg_restrict_mode
//
// Inserts and deletes each give one result through the output register.
// A listing rotates the chain one place per cycle while the result register has room, and the
// leftmost cell is emitted each step, so the queue is back in order when the listing ends.
// New requests are held off for the length of a listing and while the result register holds a result not taken.
// Reset (aresetn low, synchronous) empties the queue and clears the mode; entries are not cleared.
// A stalled result stalls both the listing and the request channel.
module restricted_circular_deque
    import rcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_operation,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [DATA_W-1:0] m_data,
    output logic              m_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_restrict_mode
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  list_left_reg, list_left_next;
    logic              mode_reg, mode_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic              slot_free;
    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  cnt_dec;
    logic [IDX_W-1:0]  last_idx;
    op_t               op;

    cell_ctrl_t        cell_ctrl [DEPTH];
    logic [DATA_W-1:0] cell_data [DEPTH];

    // Handshake and occupancy flags.
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign last_idx  = cnt_dec[IDX_W-1:0];
    assign op        = op_t'(s_operation);

    // Request decode, listing sequencer and cell commands.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        list_left_next = list_left_reg;
        mode_next      = cfg_valid ? cfg_restrict_mode : mode_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].cmd       = CELL_HOLD;
            cell_ctrl[i].load_data = s_value;
        end

        if (state_reg == S_LIST) begin
            // Emit the leftmost entry and rotate the live part of the chain left by one.
            if (slot_free) begin
                m_valid_next   = 1'b1;
                m_status_next  = STS_OK;
                m_data_next    = cell_data[0];
                m_last_next    = (list_left_reg == CNT_W'(1));
                list_left_next = list_left_reg - CNT_W'(1);
                for (int i = 0; i < DEPTH; i++) begin
                    cell_ctrl[i].load_data = cell_data[0];
                    if (i == int'(last_idx)) begin
                        cell_ctrl[i].cmd = CELL_LOAD;
                    end else begin
                        cell_ctrl[i].cmd = CELL_FROM_RIGHT;
                    end
                end
                if (list_left_reg == CNT_W'(1)) begin
                    state_next = S_IDLE;
                end
            end
        end else if (accept) begin
            m_status_next = STS_OK;
            m_data_next   = '0;
            m_last_next   = 1'b1;
            m_valid_next  = 1'b1;
            case (op)
                OP_INS_RIGHT: begin
                    if (full) begin
                        m_status_next = STS_OVERFLOW;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                            if (CNT_W'(i) == count_reg) begin
                                cell_ctrl[i].cmd = CELL_LOAD;
                            end
                        end
                    end
                end
                OP_INS_LEFT: begin
                    if (mode_reg == MODE_INPUT_RESTR) begin
                        m_status_next = STS_REFUSED;
                    end else if (full) begin
                        m_status_next = STS_OVERFLOW;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                            cell_ctrl[i].cmd = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                        end
                    end
                end
                OP_DEL_LEFT: begin
                    if (empty) begin
                        m_status_next = STS_UNDERFLOW;
                    end else begin
                        m_data_next = cell_data[0];
                        count_next  = cnt_dec;
                        for (int i = 0; i < DEPTH; i++) begin
                            cell_ctrl[i].cmd = CELL_FROM_RIGHT;
                        end
                    end
                end
                OP_DEL_RIGHT: begin
                    if (mode_reg == MODE_OUTPUT_RESTR) begin
                        m_status_next = STS_REFUSED;
                    end else if (empty) begin
                        m_status_next = STS_UNDERFLOW;
                    end else begin
                        m_data_next = cell_data[last_idx];
                        count_next  = cnt_dec;
                    end
                end
                OP_LIST: begin
                    if (empty) begin
                        m_status_next = STS_EMPTY;
                    end else begin
                        // Results follow one per cycle from the listing state while the output is not stalled.
                        m_valid_next   = 1'b0;
                        m_status_next  = m_status_reg;
                        m_data_next    = m_data_reg;
                        m_last_next    = m_last_reg;
                        list_left_next = count_reg;
                        state_next     = S_LIST;
                    end
                end
                default: begin
                    // Unused operation codes are dropped without a result.
                    m_valid_next  = 1'b0;
                    m_status_next = m_status_reg;
                    m_data_next   = m_data_reg;
                    m_last_next   = m_last_reg;
                end
            endcase
        end
    end

    // State, counters, mode and the registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            list_left_reg <= '0;
            mode_reg      <= MODE_INPUT_RESTR;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_left_reg <= list_left_next;
            mode_reg      <= mode_next;
            m_valid_reg   <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

    // The chain of entry cells, leftmost first.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_inner_l
            assign left_in = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_final
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = cell_data[g+1];
        end

        rcd_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[g]),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g])
        );
    end

`ifndef ASSERT_OFF
    // The fill count never exceeds the number of cells.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds depth");

    // A listing always has entries left to emit and keeps requests off.
    a_list_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> (list_left_reg != '0) && !s_ready)
        else $error("listing state with nothing left or request channel open");

    // A listing leaves the fill count untouched.
    a_list_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |=> $stable(count_reg))
        else $error("fill count changed during a listing");

    // An accepted insert at the right into a non-full queue grows it by one.
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_INS_RIGHT && !full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");
`endif

endmodule
